// ===== sv/midpoint_triangulation_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef MIDPOINT_TRIANGULATION_MACROS_SVH
`define MIDPOINT_TRIANGULATION_MACROS_SVH

// same-cycle implication
`define MT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midpoint_triangulation check failed");

// next-cycle implication
`define MT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midpoint_triangulation check failed");

`endif

// ===== sv/mt_pkg.sv =====
package mt_pkg;

  localparam int VEC_W    = 16;
  localparam int POS_W    = 32;
  localparam int IDX_W    = 3;
  localparam int UV_W     = 34;
  localparam int QUV_W    = 50;
  localparam int UUV_W    = 51;
  localparam int R42_W    = 53;
  localparam int BXR_W    = 33;
  localparam int DOT_W    = 33;
  localparam int C_W      = 49;
  localparam int SPLIT    = 24;
  localparam int PART_W   = 58;
  localparam int SQ_W     = 66;
  localparam int D_W      = 64;
  localparam int NUM_W    = 82;
  localparam int DIV_BITS = 96;
  localparam int LAM_W    = 47;
  localparam int LP_W     = 63;
  localparam int S30_W    = 65;

  // register stages per unit
  localparam int ROT_STG = 4;
  localparam int NRM_STG = 4;
  localparam int DIV_STG = DIV_BITS + 1;
  localparam int PT_STG  = 2;

  localparam logic [IDX_W-1:0] REG_QW = 3'd0;
  localparam logic [IDX_W-1:0] REG_QX = 3'd1;
  localparam logic [IDX_W-1:0] REG_QY = 3'd2;
  localparam logic [IDX_W-1:0] REG_QZ = 3'd3;
  localparam logic [IDX_W-1:0] REG_TX = 3'd4;
  localparam logic [IDX_W-1:0] REG_TY = 3'd5;
  localparam logic [IDX_W-1:0] REG_TZ = 3'd6;

  typedef struct packed {
    logic signed [VEC_W-1:0] first_bear_x;
    logic signed [VEC_W-1:0] first_bear_y;
    logic signed [VEC_W-1:0] first_bear_z;
    logic signed [VEC_W-1:0] second_bear_x;
    logic signed [VEC_W-1:0] second_bear_y;
    logic signed [VEC_W-1:0] second_bear_z;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] point_z;
    logic                    degenerate;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] qw;
    logic signed [VEC_W-1:0] qx;
    logic signed [VEC_W-1:0] qy;
    logic signed [VEC_W-1:0] qz;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] tz;
  } cfg_t;

  typedef logic [2:0][VEC_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t b;
    vec3_t r;
    logic  deg;
  } side_t;

endpackage

// ===== sv/mt_rot.sv =====
module mt_rot import mt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  in_t   in_data,
  input  cfg_t  cfg,
  output logic  out_vld,
  output vec3_t out_b,
  output vec3_t out_r
);

  localparam logic signed [R42_W-1:0] R_HALF = R42_W'(1) <<< 27;
  localparam logic signed [R42_W-1:0] V_MAX  = (R42_W'(1) <<< (VEC_W-1)) - 1;
  localparam logic signed [R42_W-1:0] V_MIN  = -V_MAX - 1;

  logic signed [VEC_W-1:0] u [3];
  logic vld1_r, vld2_r, vld3_r, vld4_r;
  vec3_t b1_r, v1_r, b2_r, v2_r, b3_r, v3_r, r4_r, b4_r;
  logic signed [UV_W-1:0]  uv2_r [3];
  logic signed [UV_W-1:0]  uv_nxt [3];
  logic signed [QUV_W-1:0] quv3_r [3];
  logic signed [QUV_W-1:0] quv_nxt [3];
  logic signed [UUV_W-1:0] uuv3_r [3];
  logic signed [UUV_W-1:0] uuv_nxt [3];
  vec3_t r_nxt;

  always_comb begin
    u[0] = cfg.qx;
    u[1] = cfg.qy;
    u[2] = cfg.qz;
  end

  // 2 (u x v)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uv_nxt[i] = ($signed(u[(i+1)%3]) * $signed(v1_r[(i+2)%3])
                 - $signed(u[(i+2)%3]) * $signed(v1_r[(i+1)%3])) <<< 1;
    end
  end

  // w * uv and u x uv
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quv_nxt[i] = cfg.qw * uv2_r[i];
      uuv_nxt[i] = u[(i+1)%3] * uv2_r[(i+2)%3] - u[(i+2)%3] * uv2_r[(i+1)%3];
    end
  end

  // back to Q2.14, ties up, clamp
  always_comb begin
    logic signed [R42_W-1:0] sum;
    logic signed [R42_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sum = ($signed(v3_r[i]) <<< 28) + quv3_r[i] + uuv3_r[i];
      sh  = (sum + R_HALF) >>> 28;
      if (sh > V_MAX) begin
        r_nxt[i] = V_MAX[VEC_W-1:0];
      end else if (sh < V_MIN) begin
        r_nxt[i] = V_MIN[VEC_W-1:0];
      end else begin
        r_nxt[i] = sh[VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_r <= {in_data.first_bear_z, in_data.first_bear_y, in_data.first_bear_x};
    v1_r <= {in_data.second_bear_z, in_data.second_bear_y, in_data.second_bear_x};
    b2_r <= b1_r;
    v2_r <= v1_r;
    uv2_r <= uv_nxt;
    b3_r <= b2_r;
    v3_r <= v2_r;
    quv3_r <= quv_nxt;
    uuv3_r <= uuv_nxt;
    b4_r <= b3_r;
    r4_r <= r_nxt;
  end

  assign out_vld = vld4_r;
  assign out_b   = b4_r;
  assign out_r   = r4_r;

endmodule

// ===== sv/mt_nrm.sv =====
module mt_nrm import mt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  vec3_t            in_b,
  input  vec3_t            in_r,
  input  cfg_t             cfg,
  output logic             out_vld,
  output side_t            out_side,
  output logic [NUM_W-1:0] out_mag0,
  output logic             out_neg0,
  output logic [NUM_W-1:0] out_mag1,
  output logic             out_neg1,
  output logic [D_W-1:0]   out_d
);

  logic signed [POS_W-1:0] t [3];
  logic vld5_r, vld6_r, vld7_r, vld8_r;
  vec3_t b5_r, r5_r, b6_r, r6_r, b7_r, r7_r, b8_r, r8_r;
  logic signed [BXR_W-1:0] bxr5_r [3];
  logic signed [BXR_W-1:0] bxr_nxt [3];
  logic signed [DOT_W-1:0] a00_5_r, a10_5_r, rr5_r, a00_nxt, a10_nxt, rr_nxt;
  logic signed [C_W-1:0]   c0_5_r, c1_5_r, c0_nxt, c1_nxt;
  logic [D_W-1:0]          sq6_r [3];
  logic [D_W-1:0]          sq_nxt [3];
  logic signed [PART_W-1:0] pl6_r [4];
  logic signed [PART_W-1:0] ph6_r [4];
  logic signed [PART_W-1:0] pl_nxt [4];
  logic signed [PART_W-1:0] ph_nxt [4];
  logic signed [NUM_W-1:0] prod7_r [4];
  logic signed [NUM_W-1:0] prod_nxt [4];
  logic [D_W-1:0]          d7_r, d8_r;
  logic [NUM_W-1:0]        mag0_8_r, mag1_8_r, mag0_nxt, mag1_nxt;
  logic                    neg0_8_r, neg1_8_r, deg8_r;

  always_comb begin
    t[0] = cfg.tx;
    t[1] = cfg.ty;
    t[2] = cfg.tz;
  end

  // cross product and dot products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bxr_nxt[i] = $signed(in_b[(i+1)%3]) * $signed(in_r[(i+2)%3])
                 - $signed(in_b[(i+2)%3]) * $signed(in_r[(i+1)%3]);
    end
    a00_nxt = '0;
    a10_nxt = '0;
    rr_nxt  = '0;
    c0_nxt  = '0;
    c1_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      a00_nxt = a00_nxt + $signed(in_b[i]) * $signed(in_b[i]);
      a10_nxt = a10_nxt + $signed(in_b[i]) * $signed(in_r[i]);
      rr_nxt  = rr_nxt  + $signed(in_r[i]) * $signed(in_r[i]);
      c0_nxt  = c0_nxt  + t[i] * $signed(in_b[i]);
      c1_nxt  = c1_nxt  + t[i] * $signed(in_r[i]);
    end
  end

  // squares and split partial products: rr*c0, a10*c1, a10*c0, a00*c1
  always_comb begin
    logic signed [SQ_W-1:0]   sq;
    logic signed [DOT_W-1:0]  mx [4];
    logic signed [C_W-1:0]    mc [4];
    logic signed [C_W-SPLIT:0] clo;
    logic signed [C_W-1:0]    chi;
    for (int i = 0; i < 3; i++) begin
      sq = bxr5_r[i] * bxr5_r[i];
      sq_nxt[i] = sq[D_W-1:0];
    end
    mx[0] = rr5_r;   mc[0] = c0_5_r;
    mx[1] = a10_5_r; mc[1] = c1_5_r;
    mx[2] = a10_5_r; mc[2] = c0_5_r;
    mx[3] = a00_5_r; mc[3] = c1_5_r;
    for (int k = 0; k < 4; k++) begin
      clo = $signed({2'b00, mc[k][SPLIT-1:0]});
      chi = mc[k] >>> SPLIT;
      pl_nxt[k] = mx[k] * clo;
      ph_nxt[k] = mx[k] * $signed(chi[C_W-SPLIT:0]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = (ph6_r[k] <<< SPLIT) + pl6_r[k];
    end
  end

  // numerators as sign and magnitude
  always_comb begin
    logic signed [NUM_W-1:0] n0, n1;
    n0 = prod7_r[0] - prod7_r[1];
    n1 = prod7_r[2] - prod7_r[3];
    mag0_nxt = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
    mag1_nxt = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else begin
      vld5_r <= in_vld;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    b5_r <= in_b;
    r5_r <= in_r;
    bxr5_r <= bxr_nxt;
    a00_5_r <= a00_nxt;
    a10_5_r <= a10_nxt;
    rr5_r <= rr_nxt;
    c0_5_r <= c0_nxt;
    c1_5_r <= c1_nxt;
    b6_r <= b5_r;
    r6_r <= r5_r;
    sq6_r <= sq_nxt;
    pl6_r <= pl_nxt;
    ph6_r <= ph_nxt;
    b7_r <= b6_r;
    r7_r <= r6_r;
    d7_r <= sq6_r[0] + sq6_r[1] + sq6_r[2];
    prod7_r <= prod_nxt;
    b8_r <= b7_r;
    r8_r <= r7_r;
    d8_r <= d7_r;
    deg8_r <= (d7_r == '0);
    mag0_8_r <= mag0_nxt;
    mag1_8_r <= mag1_nxt;
    neg0_8_r <= prod7_r[0] < prod7_r[1];
    neg1_8_r <= prod7_r[2] < prod7_r[3];
  end

  assign out_vld       = vld8_r;
  assign out_side.b    = b8_r;
  assign out_side.r    = r8_r;
  assign out_side.deg  = deg8_r;
  assign out_mag0      = mag0_8_r;
  assign out_neg0      = neg0_8_r;
  assign out_mag1      = mag1_8_r;
  assign out_neg1      = neg1_8_r;
  assign out_d         = d8_r;

endmodule

// ===== sv/mt_div.sv =====
module mt_div import mt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [NUM_W-1:0]        in_mag,
  input  logic                    in_neg,
  input  logic [D_W-1:0]          in_d,
  output logic                    out_vld,
  output logic signed [LAM_W-1:0] out_lam,
  output logic                    out_sat
);

  localparam logic [DIV_BITS:0] LAM_MAX = ((DIV_BITS+1)'(1) << (LAM_W-1)) - 1'b1;

  // one quotient bit per stage; mq shifts dividend out and quotient in
  logic                vld_r [DIV_BITS];
  logic [D_W-1:0]      rem_r [DIV_BITS];
  logic [DIV_BITS-1:0] mq_r  [DIV_BITS];
  logic [D_W-1:0]      d_r   [DIV_BITS];
  logic                neg_r [DIV_BITS];
  logic [D_W-1:0]      rem_nxt [DIV_BITS];
  logic [DIV_BITS-1:0] mq_nxt  [DIV_BITS];
  logic                fvld_r, fsat_r;
  logic signed [LAM_W-1:0] flam_r, lam_nxt;
  logic                sat_nxt;

  always_comb begin
    logic [D_W-1:0]      srem;
    logic [DIV_BITS-1:0] smq;
    logic [D_W-1:0]      sd;
    logic [D_W:0]        sh;
    logic                ge;
    for (int k = 0; k < DIV_BITS; k++) begin
      if (k == 0) begin
        srem = '0;
        smq  = {in_mag, (DIV_BITS-NUM_W)'(0)};
        sd   = in_d;
      end else begin
        srem = rem_r[k-1];
        smq  = mq_r[k-1];
        sd   = d_r[k-1];
      end
      sh = {srem, smq[DIV_BITS-1]};
      ge = sh >= {1'b0, sd};
      rem_nxt[k] = ge ? D_W'(sh - {1'b0, sd}) : sh[D_W-1:0];
      mq_nxt[k]  = {smq[DIV_BITS-2:0], ge};
    end
  end

  // round half away from zero, clamp depth
  always_comb begin
    logic              rnd;
    logic [DIV_BITS:0] qf;
    logic [LAM_W-1:0]  mag;
    rnd = {rem_r[DIV_BITS-1], 1'b0} >= {1'b0, d_r[DIV_BITS-1]};
    qf  = {1'b0, mq_r[DIV_BITS-1]} + (DIV_BITS+1)'(rnd);
    sat_nxt = qf > LAM_MAX;
    mag = sat_nxt ? LAM_MAX[LAM_W-1:0] : qf[LAM_W-1:0];
    lam_nxt = neg_r[DIV_BITS-1] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_BITS; k++) begin
        vld_r[k] <= 1'b0;
      end
      fvld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < DIV_BITS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      fvld_r <= vld_r[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    mq_r  <= mq_nxt;
    d_r[0]   <= in_d;
    neg_r[0] <= in_neg;
    for (int k = 1; k < DIV_BITS; k++) begin
      d_r[k]   <= d_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
    flam_r <= lam_nxt;
    fsat_r <= sat_nxt;
  end

  assign out_vld = fvld_r;
  assign out_lam = flam_r;
  assign out_sat = fsat_r;

endmodule

// ===== sv/mt_pt.sv =====
module mt_pt import mt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [LAM_W-1:0] in_lam0,
  input  logic signed [LAM_W-1:0] in_lam1,
  input  logic                    in_sat,
  input  side_t                   in_side,
  input  cfg_t                    cfg,
  output logic                    out_vld,
  output out_t                    out_data
);

  localparam int P_W = S30_W - 15;
  localparam logic signed [S30_W-1:0] P_HALF = S30_W'(1) <<< 14;
  localparam logic signed [P_W-1:0]   P_MAX  = (P_W'(1) <<< (POS_W-1)) - 1;
  localparam logic signed [P_W-1:0]   P_MIN  = -P_MAX - 1;

  logic signed [POS_W-1:0] t [3];
  logic                    vld9_r, vld10_r, sat9_r, deg9_r;
  logic signed [LP_W-1:0]  pb9_r [3];
  logic signed [LP_W-1:0]  pr9_r [3];
  logic signed [LP_W-1:0]  pb_nxt [3];
  logic signed [LP_W-1:0]  pr_nxt [3];
  out_t                    res_r, res_nxt;

  always_comb begin
    t[0] = cfg.tx;
    t[1] = cfg.ty;
    t[2] = cfg.tz;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pb_nxt[i] = in_lam0 * $signed(in_side.b[i]);
      pr_nxt[i] = in_lam1 * $signed(in_side.r[i]);
    end
  end

  always_comb begin
    logic signed [S30_W-1:0] s30;
    logic signed [P_W-1:0]   p;
    logic signed [POS_W-1:0] c [3];
    logic                    hit;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s30 = pb9_r[i] + pr9_r[i] + (t[i] <<< 14);
      s30 = (s30 + P_HALF) >>> 15;
      p   = s30[P_W-1:0];
      if (p > P_MAX) begin
        c[i] = P_MAX[POS_W-1:0];
        hit  = 1'b1;
      end else if (p < P_MIN) begin
        c[i] = P_MIN[POS_W-1:0];
        hit  = 1'b1;
      end else begin
        c[i] = p[POS_W-1:0];
      end
    end
    if (deg9_r) begin
      res_nxt.point_x    = '0;
      res_nxt.point_y    = '0;
      res_nxt.point_z    = '0;
      res_nxt.degenerate = 1'b1;
      res_nxt.saturated  = 1'b0;
    end else begin
      res_nxt.point_x    = c[0];
      res_nxt.point_y    = c[1];
      res_nxt.point_z    = c[2];
      res_nxt.degenerate = 1'b0;
      res_nxt.saturated  = hit | sat9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld9_r  <= 1'b0;
      vld10_r <= 1'b0;
    end else begin
      vld9_r  <= in_vld;
      vld10_r <= vld9_r;
    end
  end

  always_ff @(posedge clk) begin
    pb9_r  <= pb_nxt;
    pr9_r  <= pr_nxt;
    sat9_r <= in_sat;
    deg9_r <= in_side.deg;
    res_r  <= res_nxt;
  end

  assign out_vld  = vld10_r;
  assign out_data = res_r;

endmodule

// ===== sv/midpoint_triangulation.sv =====
// Channel  Ports                              Handshake
// in       start, busy, in_data               request taken when start && !busy
// out      out_valid, out_data                one-cycle strobe, no back-pressure
// cfg      cfg_valid, cfg_ready, cfg_index,   write when cfg_valid && cfg_ready
//          cfg_data
//
// One request per cycle, sustained; busy stays low.
// The depth divider resolves one quotient bit per stage.
// Reset (synchronous, rst_n low) clears the valid bits and loads the
// configuration defaults: identity rotation, zero translation.
// Nothing stalls: results leave on the strobe and must be taken then.
`include "midpoint_triangulation_macros.svh"

module midpoint_triangulation import mt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0] cfg_data
);

  localparam int LAT = ROT_STG + NRM_STG + DIV_STG + PT_STG;

  cfg_t cfg_r;

  logic             rot_vld, nrm_vld, div0_vld, div1_vld;
  vec3_t            rot_b, rot_r;
  side_t            nrm_side;
  logic [NUM_W-1:0] mag0, mag1;
  logic             neg0, neg1;
  logic [D_W-1:0]   dval;
  logic signed [LAM_W-1:0] lam0, lam1;
  logic             sat0, sat1;

  // b, r and the degenerate flag ride alongside the divider
  side_t side_r [DIV_STG];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // config registers; out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qw <= 16'sd16384;
      cfg_r.qx <= '0;
      cfg_r.qy <= '0;
      cfg_r.qz <= '0;
      cfg_r.tx <= '0;
      cfg_r.ty <= '0;
      cfg_r.tz <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QW:  cfg_r.qw <= cfg_data[VEC_W-1:0];
        REG_QX:  cfg_r.qx <= cfg_data[VEC_W-1:0];
        REG_QY:  cfg_r.qy <= cfg_data[VEC_W-1:0];
        REG_QZ:  cfg_r.qz <= cfg_data[VEC_W-1:0];
        REG_TX:  cfg_r.tx <= cfg_data;
        REG_TY:  cfg_r.ty <= cfg_data;
        REG_TZ:  cfg_r.tz <= cfg_data;
        default: ;
      endcase
    end
  end

  // rotate second bearing into camera one frame
  mt_rot u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_data (in_data),
    .cfg     (cfg_r),
    .out_vld (rot_vld),
    .out_b   (rot_b),
    .out_r   (rot_r)
  );

  // normal system, determinant and depth numerators
  mt_nrm u_nrm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rot_vld),
    .in_b     (rot_b),
    .in_r     (rot_r),
    .cfg      (cfg_r),
    .out_vld  (nrm_vld),
    .out_side (nrm_side),
    .out_mag0 (mag0),
    .out_neg0 (neg0),
    .out_mag1 (mag1),
    .out_neg1 (neg1),
    .out_d    (dval)
  );

  // depth along first ray
  mt_div u_div0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (nrm_vld),
    .in_mag  (mag0),
    .in_neg  (neg0),
    .in_d    (dval),
    .out_vld (div0_vld),
    .out_lam (lam0),
    .out_sat (sat0)
  );

  // depth along second ray
  mt_div u_div1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (nrm_vld),
    .in_mag  (mag1),
    .in_neg  (neg1),
    .in_d    (dval),
    .out_vld (div1_vld),
    .out_lam (lam1),
    .out_sat (sat1)
  );

  always_ff @(posedge clk) begin
    side_r[0] <= nrm_side;
    for (int k = 1; k < DIV_STG; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // midpoint, round and clamp
  mt_pt u_pt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div0_vld),
    .in_lam0  (lam0),
    .in_lam1  (lam1),
    .in_sat   (sat0 | sat1),
    .in_side  (side_r[DIV_STG-1]),
    .cfg      (cfg_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  // every result traces back to an accepted request
  `MT_ASSERT_IMP(a_latency, out_valid, $past(start && !busy, LAT))
  // both depth dividers stay in lock step
  `MT_ASSERT_IMP(a_div_sync, 1'b1, div0_vld == div1_vld)
  // a degenerate result carries a zero point and no clamp flag
  `MT_ASSERT_IMP(a_degenerate, out_valid && out_data.degenerate,
    out_data.point_x == '0 && out_data.point_y == '0 &&
    out_data.point_z == '0 && !out_data.saturated)

endmodule
